/* rtl/core/lswq_pkg.sv */
// ---------------------------------------------------------------------------
// lswq_pkg
// Shared types and constants of the seam tracking quality unit.
// ---------------------------------------------------------------------------
package lswq_pkg;

   localparam int LINE_POINTS_DEF = 1024;

   localparam int HEIGHT_W = 16;
   localparam int RANK_W   = 8;
   localparam int WIN_W    = 13;
   localparam int LEN_W    = 10;
   localparam int PCT_W    = 15;
   localparam int JCOL_W   = 10;
   localparam int MJ_W     = 12;
   localparam int MG_W     = 10;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [PCT_W-1:0] PCT_FULL = 15'd25600;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_JUMP   = 2'd0,
      CSR_MAX_GAP    = 2'd1,
      CSR_GAP_THRESH = 2'd2,
      CSR_WALK_DIR   = 2'd3
   } csr_idx_type;

   typedef struct packed {
      logic [MJ_W-1:0]  max_jump;
      logic [MG_W-1:0]  max_gap_points;
      logic [PCT_W-1:0] gap_threshold;
      logic             walk_from_right;
   } cfg_type;

   typedef enum logic [4:0] {
      S_LOAD = 5'b00001,
      S_CNT  = 5'b00010,
      S_DIV  = 5'b00100,
      S_WALK = 5'b01000,
      S_OUT  = 5'b10000
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic frame_last;
      logic cnt_run;
      logic div_start;
      logic div_run;
      logic walk_start;
      logic walk_run;
      logic rank_rd;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic cnt_done;
      logic div_done;
      logic walk_done;
      logic rsp_busy;
   } status_type;

endpackage

/* rtl/core/lswq_if.sv */
// ---------------------------------------------------------------------------
// lswq channel interfaces
// Request, response and register write channels with valid/ready.
// ---------------------------------------------------------------------------
interface lswq_req_if;
   logic              valid;
   logic              ready;
   logic [15:0]       sample_height;
   logic [7:0]        sample_rank;
   logic signed [12:0] window_start;
   logic signed [12:0] window_end;
   logic              frame_invalid;
   logic              last_point;

   modport source (output valid, sample_height, sample_rank, window_start, window_end,
                   frame_invalid, last_point, input ready);
   modport sink (input valid, sample_height, sample_rank, window_start, window_end,
                 frame_invalid, last_point, output ready);
endinterface

interface lswq_rsp_if;
   logic        valid;
   logic        ready;
   logic [9:0]  tracked_length;
   logic [7:0]  length_rank;
   logic [14:0] tracked_percent;
   logic        gap_detected;
   logic [9:0]  jump_column;
   logic [15:0] jump_height;

   modport source (output valid, tracked_length, length_rank, tracked_percent, gap_detected,
                   jump_column, jump_height, input ready);
   modport sink (input valid, tracked_length, length_rank, tracked_percent, gap_detected,
                 jump_column, jump_height, output ready);
endinterface

interface lswq_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink (input valid, index, wdata, output ready);
endinterface

/* rtl/core/laser_line_seam_tracking_quality_unit.sv */
// ---------------------------------------------------------------------------
// laser_line_seam_tracking_quality_unit
// Seam tracking quality of one laser-line profile.
// ---------------------------------------------------------------------------
// Profile points are taken one per cycle while the unit is loading and
// stored in two single-port-read RAMs. After the point marked last the
// unit takes no request until its result is formed: it counts valid points
// in the window (one RAM read a cycle), runs the bit-serial percentage
// divider, then the walk, one column a cycle once its window has filled,
// and one rank read. An invalid frame skips all of it. The result sits in
// an output register, so loading of the next line starts while it waits
// to be taken.
module laser_line_seam_tracking_quality_unit #(
   parameter int LINE_POINTS = lswq_pkg::LINE_POINTS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   lswq_req_if.sink   req_bus,
   lswq_rsp_if.source rsp_bus,
   lswq_csr_if.sink   csr_bus
);
   import lswq_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       req_ready;

   assign req_bus.ready = req_ready;

   lswq_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_bus.valid),
      .req_last    (req_bus.last_point),
      .req_invalid (req_bus.frame_invalid),
      .status      (status),
      .req_ready   (req_ready),
      .cmd         (cmd)
   );

   lswq_datapath #(.LINE_POINTS(LINE_POINTS)) u_datapath (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .csr_bus (csr_bus),
      .rsp_bus (rsp_bus),
      .cmd     (cmd),
      .status  (status)
   );
endmodule

/* rtl/core/lswq_ram.sv */
// ---------------------------------------------------------------------------
// lswq_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ---------------------------------------------------------------------------
module lswq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

/* rtl/core/lswq_datapath.sv */
// ---------------------------------------------------------------------------
// lswq_datapath
// Profile store, window count, percentage divider, walk and result register.
// ---------------------------------------------------------------------------
module lswq_datapath #(
   parameter int LINE_POINTS = lswq_pkg::LINE_POINTS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   lswq_req_if.sink             req_bus,
   lswq_csr_if.sink             csr_bus,
   lswq_rsp_if.source           rsp_bus,
   input  lswq_pkg::cmd_type    cmd,
   output lswq_pkg::status_type status
);
   import lswq_pkg::*;

   localparam int AW  = $clog2(LINE_POINTS);
   localparam int CW  = $clog2(LINE_POINTS + 1);
   localparam int PW  = ((CW > 12) ? CW : 12) + 2;
   localparam int DW  = CW + PCT_W;
   localparam int DCW = $clog2(DW + 1);
   localparam int SW  = (CW > LEN_W) ? CW : LEN_W;
   localparam logic signed [PW-1:0] SONE = 1;
   localparam logic signed [PW-1:0] STWO = 2;
   localparam logic signed [PW-1:0] SZERO = 0;

   // configuration
   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_jump        <= MJ_W'(5);
         cfg_ff.max_gap_points  <= MG_W'(10);
         cfg_ff.gap_threshold   <= PCT_FULL;
         cfg_ff.walk_from_right <= 1'b0;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_MAX_JUMP:   cfg_ff.max_jump        <= csr_bus.wdata[MJ_W-1:0];
            CSR_MAX_GAP:    cfg_ff.max_gap_points  <= csr_bus.wdata[MG_W-1:0];
            CSR_GAP_THRESH: cfg_ff.gap_threshold   <= csr_bus.wdata[PCT_W-1:0];
            CSR_WALK_DIR:   cfg_ff.walk_from_right <= csr_bus.wdata[0];
            default:        cfg_ff <= cfg_ff;
         endcase
      end
   end

   assign csr_bus.ready = 1'b1;

   // profile store
   logic [CW-1:0]       count_ff;
   logic                wr_en;
   logic                rd_en;
   logic [AW-1:0]       rd_addr;
   logic [HEIGHT_W-1:0] h_q;
   logic [RANK_W-1:0]   r_q;

   assign wr_en = cmd.load && (count_ff < CW'(LINE_POINTS));

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.frame_last) begin
         count_ff <= '0;
      end else if (wr_en) begin
         count_ff <= count_ff + CW'(1);
      end
   end

   lswq_ram #(.WIDTH(HEIGHT_W), .DEPTH(LINE_POINTS)) u_height_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (req_bus.sample_height),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (h_q)
   );

   lswq_ram #(.WIDTH(RANK_W), .DEPTH(LINE_POINTS)) u_rank_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (req_bus.sample_rank),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (r_q)
   );

   // window bounds on the last request
   logic [CW-1:0]         len_u;
   logic signed [PW-1:0]  len_s, ws, we, lo, hi, xs_in, xe_in;
   logic signed [PW-1:0]  len_ff, xs_ff, xe_ff;
   logic                  inv_ff;

   always_comb begin
      len_u = count_ff + CW'(count_ff < CW'(LINE_POINTS));
      len_s = $signed({{(PW-CW){1'b0}}, len_u});
      ws    = PW'(req_bus.window_start);
      we    = PW'(req_bus.window_end);
      lo    = (we < ws) ? we : ws;
      hi    = (we < ws) ? ws : we;
      xs_in = (lo < SZERO) ? SZERO : lo;
      xe_in = (hi > len_s - SONE) ? len_s - SONE : hi;
   end

   // valid point count
   logic signed [PW-1:0] cnt_p_ff;
   logic [CW-1:0]        hits_ff;
   logic                 rd_vld_ff;
   logic                 cnt_issue;
   logic                 walk_issue;

   assign cnt_issue = cmd.cnt_run && (cnt_p_ff <= xe_ff);

   always_ff @(posedge clock) begin
      if (cmd.frame_last) begin
         inv_ff   <= req_bus.frame_invalid;
         len_ff   <= len_s;
         xs_ff    <= xs_in;
         xe_ff    <= xe_in;
         cnt_p_ff <= xs_in;
         hits_ff  <= '0;
      end else begin
         if (cnt_issue) begin
            cnt_p_ff <= cnt_p_ff + SONE;
         end
         if (cmd.cnt_run && rd_vld_ff && (r_q != '0)) begin
            hits_ff <= hits_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= rd_en;
      end
   end

   // percentage divider, one quotient bit a cycle
   logic signed [PW-1:0] num_s;
   logic [CW-1:0]        num_u;
   logic [DW-1:0]        dq_ff;
   logic [CW-1:0]        rem_ff;
   logic [CW:0]          rem_sh;
   logic [DCW-1:0]       div_cnt_ff;
   logic                 q_bit;
   logic [PCT_W-1:0]     pct;

   always_comb begin
      num_s  = xe_ff - xs_ff + SONE;
      num_u  = (num_s < SONE) ? CW'(1) : num_s[CW-1:0];
      rem_sh = {rem_ff, dq_ff[DW-1]};
      q_bit  = (rem_sh >= {1'b0, num_u});
      pct    = (dq_ff > DW'(PCT_FULL)) ? PCT_FULL : dq_ff[PCT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= '0;
      end else if (cmd.div_start) begin
         div_cnt_ff <= DCW'(DW);
      end else if (cmd.div_run && (div_cnt_ff != '0)) begin
         div_cnt_ff <= div_cnt_ff - DCW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         dq_ff  <= DW'(hits_ff) * DW'(PCT_FULL);
         rem_ff <= '0;
      end else if (cmd.div_run && (div_cnt_ff != '0)) begin
         rem_ff <= q_bit ? CW'(rem_sh - {1'b0, num_u}) : rem_sh[CW-1:0];
         dq_ff  <= {dq_ff[DW-2:0], q_bit};
      end
   end

   // walk over a three point window streamed from the store
   logic signed [PW-1:0] xs2, xe2, lim;
   logic signed [PW-1:0] p_ff, rd_p_ff, bnd_ff, p_nx, dstep;
   logic                 dir_ff, wdone_ff, first_ff, gap_ff;
   logic [1:0]           wcnt_ff;
   logic [HEIGHT_W-1:0]  hp_ff, hc_ff, hn_ff, gh_ff, jh_ff;
   logic [RANK_W-1:0]    rp_ff, rc_ff, rn_ff;
   logic [MG_W:0]        ctr_ff, ctr_inc;
   logic [JCOL_W-1:0]    gcol_ff, jc_ff;
   logic [CW-1:0]        steps_ff;
   logic [HEIGHT_W-1:0]  mj, d_prev, d_next, d_gap;
   logic                 rc_nz, rp_nz, f_nx, eval, stop, at_end;
   logic [JCOL_W-1:0]    stop_col;
   logic [HEIGHT_W-1:0]  stop_h;

   assign walk_issue = cmd.walk_run && !wdone_ff;
   assign eval       = walk_issue && rd_vld_ff && (wcnt_ff == 2'd3);

   always_comb begin
      xs2     = (xs_ff < STWO) ? STWO : xs_ff;
      xe2     = (xe_ff > len_ff - STWO) ? len_ff - STWO : xe_ff;
      lim     = xe2 - SONE;
      dstep   = dir_ff ? -SONE : SONE;
      mj      = {cfg_ff.max_jump, 4'b0000};
      d_prev  = (hc_ff > hp_ff) ? hc_ff - hp_ff : hp_ff - hc_ff;
      d_next  = (hn_ff > hc_ff) ? hn_ff - hc_ff : hc_ff - hn_ff;
      d_gap   = dir_ff ? d_prev : d_next;
      rc_nz   = (rc_ff != '0);
      rp_nz   = (rp_ff != '0);
      f_nx    = first_ff || rc_nz;
      ctr_inc = ctr_ff + (MG_W+1)'(1);
      p_nx    = p_ff + dstep;
      at_end  = dir_ff ? (p_nx <= bnd_ff) : (p_nx >= bnd_ff);
      stop     = 1'b0;
      stop_col = gcol_ff;
      stop_h   = gh_ff;
      if (!gap_ff) begin
         if (f_nx && rc_nz && rp_nz) begin
            if (d_prev >= mj) begin
               stop     = 1'b1;
               stop_col = p_ff[JCOL_W-1:0];
               stop_h   = hc_ff;
            end
         end else if (f_nx && !rc_nz) begin
            if (cfg_ff.max_gap_points == '0) begin
               stop     = 1'b1;
               stop_col = p_ff[JCOL_W-1:0];
               stop_h   = hp_ff;
            end
         end
      end else begin
         if (!rc_nz) begin
            stop = (ctr_inc > {1'b0, cfg_ff.max_gap_points});
         end else begin
            stop = (d_gap > mj);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wdone_ff <= 1'b0;
      end else if (cmd.walk_start) begin
         wdone_ff <= cfg_ff.walk_from_right ? (xe2 <= xs2) : (xs2 >= lim);
      end else if (eval && (stop || at_end)) begin
         wdone_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.walk_start) begin
         dir_ff   <= cfg_ff.walk_from_right;
         p_ff     <= cfg_ff.walk_from_right ? xe2 : xs2;
         rd_p_ff  <= cfg_ff.walk_from_right ? xe2 + SONE : xs2 - SONE;
         bnd_ff   <= cfg_ff.walk_from_right ? xs2 : lim;
         wcnt_ff  <= 2'd0;
         first_ff <= 1'b0;
         gap_ff   <= 1'b0;
         ctr_ff   <= '0;
         steps_ff <= '0;
         jc_ff    <= '0;
         jh_ff    <= '0;
      end else if (walk_issue) begin
         rd_p_ff <= rd_p_ff + dstep;
         if (rd_vld_ff) begin
            hp_ff <= hc_ff;
            hc_ff <= hn_ff;
            hn_ff <= h_q;
            rp_ff <= rc_ff;
            rc_ff <= rn_ff;
            rn_ff <= r_q;
            if (wcnt_ff != 2'd3) begin
               wcnt_ff <= wcnt_ff + 2'd1;
            end
         end
         if (eval) begin
            p_ff <= p_nx;
            if (stop) begin
               jc_ff <= stop_col;
               jh_ff <= stop_h;
            end
            if (!gap_ff) begin
               first_ff <= f_nx;
               if (f_nx && rc_nz && rp_nz && !stop) begin
                  steps_ff <= steps_ff + CW'(1);
               end else if (f_nx && !rc_nz) begin
                  gcol_ff <= p_ff[JCOL_W-1:0];
                  gh_ff   <= hp_ff;
                  ctr_ff  <= (MG_W+1)'(1);
                  gap_ff  <= 1'b1;
               end
            end else if (!rc_nz) begin
               ctr_ff <= ctr_inc;
            end else begin
               gap_ff <= 1'b0;
            end
         end
      end
   end

   // read port select
   always_comb begin
      rd_en   = cnt_issue || walk_issue || cmd.rank_rd;
      rd_addr = steps_ff[AW-1:0];
      priority if (cnt_issue) begin
         rd_addr = cnt_p_ff[AW-1:0];
      end else if (walk_issue) begin
         rd_addr = rd_p_ff[AW-1:0];
      end
   end

   // result register
   logic              rsp_valid_ff;
   logic [LEN_W-1:0]  rsp_len_ff;
   logic [RANK_W-1:0] rsp_rank_ff;
   logic [PCT_W-1:0]  rsp_pct_ff;
   logic              rsp_gap_ff;
   logic [JCOL_W-1:0] rsp_col_ff;
   logic [HEIGHT_W-1:0] rsp_h_ff;
   logic [SW-1:0]     steps_w;

   assign steps_w = SW'(steps_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         if (inv_ff) begin
            rsp_len_ff  <= '0;
            rsp_rank_ff <= '0;
            rsp_pct_ff  <= '0;
            rsp_gap_ff  <= 1'b0;
            rsp_col_ff  <= '0;
            rsp_h_ff    <= '0;
         end else begin
            rsp_len_ff  <= (steps_w > SW'(1023)) ? LEN_W'(1023) : steps_w[LEN_W-1:0];
            rsp_rank_ff <= r_q;
            rsp_pct_ff  <= pct;
            rsp_gap_ff  <= (pct < cfg_ff.gap_threshold);
            rsp_col_ff  <= jc_ff;
            rsp_h_ff    <= jh_ff;
         end
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.tracked_length  = rsp_len_ff;
   assign rsp_bus.length_rank     = rsp_rank_ff;
   assign rsp_bus.tracked_percent = rsp_pct_ff;
   assign rsp_bus.gap_detected    = rsp_gap_ff;
   assign rsp_bus.jump_column     = rsp_col_ff;
   assign rsp_bus.jump_height     = rsp_h_ff;

   always_comb begin
      status.cnt_done  = !(cnt_p_ff <= xe_ff) && !rd_vld_ff;
      status.div_done  = (div_cnt_ff == '0);
      status.walk_done = wdone_ff;
      status.rsp_busy  = rsp_valid_ff && !rsp_bus.ready;
   end
endmodule

/* rtl/core/lswq_ctrl.sv */
// ---------------------------------------------------------------------------
// lswq_ctrl
// Phase sequencer: load, count, divide, walk, hand off result.
// ---------------------------------------------------------------------------
module lswq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_last,
   input  logic                 req_invalid,
   input  lswq_pkg::status_type status,
   output logic                 req_ready,
   output lswq_pkg::cmd_type    cmd
);
   import lswq_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           acc;

   assign acc = req_valid && (state_ff == S_LOAD);

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         S_LOAD: begin
            req_ready = 1'b1;
            cmd.load  = acc;
            if (acc && req_last) begin
               cmd.frame_last = 1'b1;
               state_in       = req_invalid ? S_OUT : S_CNT;
            end
         end
         S_CNT: begin
            cmd.cnt_run = 1'b1;
            if (status.cnt_done) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_run = 1'b1;
            if (status.div_done) begin
               cmd.walk_start = 1'b1;
               state_in       = S_WALK;
            end
         end
         S_WALK: begin
            cmd.walk_run = 1'b1;
            if (status.walk_done) begin
               cmd.rank_rd = 1'b1;
               state_in    = S_OUT;
            end
         end
         S_OUT: begin
            if (!status.rsp_busy) begin
               cmd.out_load = 1'b1;
               state_in     = S_LOAD;
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef ASSERT_OFF
   a_invalid_skips: assert property (@(posedge clock) disable iff (reset)
      (acc && req_last && req_invalid) |=> (state_ff == S_OUT))
      else $error("invalid frame did not go straight to result");
   a_cnt_to_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CNT && status.cnt_done) |=> (state_ff == S_DIV && !status.div_done))
      else $error("divider not started after count");
   a_walk_to_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK && status.walk_done) |=> (state_ff == S_OUT))
      else $error("walk end not followed by result");
`endif
endmodule

/* tb/tb_top.sv */
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the laser-line seam tracking quality unit.
// Streams profile lines through the request channel, predicts each result
// with a local model of the window count, percentage and walk, and checks
// every response field by field under random stalls on both sides.
// ---------------------------------------------------------------------------
module tb_top;
   import lswq_pkg::*;

   localparam int NPTS      = LINE_POINTS_DEF;
   localparam int CYCLE_MAX = 1000000;

   typedef struct {
      logic [15:0]        height;
      logic [7:0]         rank;
      logic signed [12:0] wstart;
      logic signed [12:0] wend;
      logic               invalid;
      logic               last;
   } point_t;

   typedef struct {
      logic [9:0]  length;
      logic [7:0]  lrank;
      logic [14:0] pct;
      logic        gap;
      logic [9:0]  jcol;
      logic [15:0] jheight;
   } quality_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lswq_req_if req_bus ();
   lswq_rsp_if rsp_bus ();
   lswq_csr_if csr_bus ();

   laser_line_seam_tracking_quality_unit u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #5 clock = ~clock;

   point_t   point_queue[$];
   quality_t quality_queue[$];
   logic [15:0] height_mem[NPTS];
   logic [7:0]  rank_mem[NPTS];
   int       stored_count = 0;
   int       cfg_max_jump = 5;
   int       cfg_max_gap = 10;
   int       cfg_gap_thresh = 25600;
   bit       cfg_right = 1'b0;
   int       errors = 0;
   int       cycles = 0;
   bit       quiet = 1'b0;
   bit       req_taken = 1'b0;
   bit       holding = 1'b0;
   point_t   cur;
   int       req_gap = 0;
   int       rsp_gap = 0;

   task automatic report(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
   endtask

   function automatic int rank_at(input int i);
      if (i < 0 || i >= NPTS) return 0;
      return rank_mem[i];
   endfunction

   function automatic int height_at(input int i);
      if (i < 0 || i >= NPTS) return 0;
      return height_mem[i];
   endfunction

   function automatic int adiff(input int a, input int b);
      return a > b ? a - b : b - a;
   endfunction

   function automatic quality_t line_quality(input point_t p, input int len);
      quality_t q;
      int xs, xe, t, num, cnt, pct, lim, x, i, steps, jc, jh, ctr, mj;
      bit first, stop, found;
      q = '{default: '0};
      steps = 0; jc = 0; jh = 0; cnt = 0; first = 0;
      mj = cfg_max_jump * 16;
      if (p.invalid) return q;
      if (len == 0) len = 1;
      xs = p.wstart;
      xe = p.wend;
      if (xe < xs) begin
         t = xs; xs = xe; xe = t;
      end
      if (xs < 0) xs = 0;
      if (xe > len - 1) xe = len - 1;
      num = xe - xs + 1;
      if (num <= 0) num = 1;
      for (i = xs; i <= xe; i++)
         if (rank_at(i) > 0) cnt++;
      pct = (25600 * cnt) / num;
      if (pct > 25600) pct = 25600;
      if (xs < 2) xs = 2;
      if (xe > len - 2) xe = len - 2;
      if (!cfg_right) begin
         lim = xe - 1;
         for (x = xs; x < lim; x++) begin
            if (!first && rank_at(x) > 0) first = 1;
            if (first && rank_at(x) > 0 && rank_at(x - 1) > 0) begin
               if (adiff(height_at(x), height_at(x - 1)) < mj) steps++;
               else begin
                  jc = x; jh = height_at(x); break;
               end
            end else if (first && rank_at(x) == 0) begin
               stop = 0; found = 0; ctr = 0;
               for (i = x; i < lim; i++) begin
                  if (rank_at(i) == 0) begin
                     ctr++;
                     if (ctr > cfg_max_gap) begin
                        stop = 1; break;
                     end
                  end else if (adiff(height_at(i + 1), height_at(i)) > mj) begin
                     stop = 1; break;
                  end else begin
                     found = 1; break;
                  end
               end
               if (stop) begin
                  jc = x; jh = height_at(x - 1); break;
               end
               if (!found) break;
               x = i;
            end
         end
      end else begin
         for (x = xe; x > xs; x--) begin
            if (!first && rank_at(x) > 0) first = 1;
            if (first && rank_at(x) > 0 && rank_at(x + 1) > 0) begin
               if (adiff(height_at(x), height_at(x + 1)) < mj) steps++;
               else begin
                  jc = x; jh = height_at(x); break;
               end
            end else if (first && rank_at(x) == 0) begin
               stop = 0; found = 0; ctr = 0;
               for (i = x; i > xs; i--) begin
                  if (rank_at(i) == 0) begin
                     ctr++;
                     if (ctr > cfg_max_gap) begin
                        stop = 1; break;
                     end
                  end else if (adiff(height_at(i + 1), height_at(i)) > mj) begin
                     stop = 1; break;
                  end else begin
                     found = 1; break;
                  end
               end
               if (stop) begin
                  jc = x; jh = height_at(x + 1); break;
               end
               if (!found) break;
               x = i;
            end
         end
      end
      q.length  = steps > 1023 ? 10'd1023 : 10'(steps);
      q.lrank   = 8'(rank_at(steps));
      q.pct     = 15'(pct);
      q.gap     = pct < cfg_gap_thresh;
      q.jcol    = 10'(jc);
      q.jheight = 16'(jh);
      return q;
   endfunction

   // acceptance, prediction and response check
   always @(posedge clock) begin
      point_t   p;
      quality_t got, want;
      int       len;
      cycles++;
      if (cycles > CYCLE_MAX) begin
         $display("FAIL laser_line_seam_tracking_quality_unit");
         $finish;
      end
      req_taken = !reset && req_bus.valid && req_bus.ready;
      if (!reset && csr_bus.valid && csr_bus.ready) begin
         case (csr_idx_type'(csr_bus.index))
            CSR_MAX_JUMP:   cfg_max_jump = csr_bus.wdata[11:0];
            CSR_MAX_GAP:    cfg_max_gap = csr_bus.wdata[9:0];
            CSR_GAP_THRESH: cfg_gap_thresh = csr_bus.wdata[14:0];
            CSR_WALK_DIR:   cfg_right = csr_bus.wdata[0];
         endcase
      end
      if (req_taken) begin
         p = cur;
         if (stored_count < NPTS) begin
            height_mem[stored_count] = p.height;
            rank_mem[stored_count] = p.rank;
            stored_count++;
         end
         if (p.last) begin
            len = stored_count;
            stored_count = 0;
            quality_queue.push_back(line_quality(p, len));
         end
      end
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = '{rsp_bus.tracked_length, rsp_bus.length_rank, rsp_bus.tracked_percent,
                 rsp_bus.gap_detected, rsp_bus.jump_column, rsp_bus.jump_height};
         if (quality_queue.size() == 0) report("unexpected response", 1, 0);
         else begin
            want = quality_queue.pop_front();
            if (got.length !== want.length) report("tracked_length", got.length, want.length);
            if (got.lrank !== want.lrank) report("length_rank", got.lrank, want.lrank);
            if (got.pct !== want.pct) report("tracked_percent", got.pct, want.pct);
            if (got.gap !== want.gap) report("gap_detected", got.gap, want.gap);
            if (got.jcol !== want.jcol) report("jump_column", got.jcol, want.jcol);
            if (got.jheight !== want.jheight) report("jump_height", got.jheight, want.jheight);
         end
      end
   end

   // request driver and response stalls
   always @(negedge clock) begin
      if (holding && req_taken) holding = 0;
      if (!holding && !reset) begin
         if (req_gap > 0) req_gap--;
         else if (point_queue.size() > 0) begin
            if (!quiet && $urandom_range(0, 7) == 0) req_gap = $urandom_range(0, 8);
            else begin
               cur = point_queue.pop_front();
               holding = 1;
            end
         end
      end
      req_bus.valid         = holding;
      req_bus.sample_height = cur.height;
      req_bus.sample_rank   = cur.rank;
      req_bus.window_start  = cur.wstart;
      req_bus.window_end    = cur.wend;
      req_bus.frame_invalid = cur.invalid;
      req_bus.last_point    = cur.last;
      if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_bus.ready = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         rsp_gap = $urandom_range(0, 8);
         rsp_bus.ready = 1'b0;
      end else
         rsp_bus.ready = 1'b1;
   end

   task automatic csr_write(input csr_idx_type idx, input int data);
      @(negedge clock);
      csr_bus.valid = 1'b1;
      csr_bus.index = idx;
      csr_bus.wdata = 16'(data);
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   task automatic set_config(input int mj, input int mg, input int th, input int dir);
      csr_write(CSR_MAX_JUMP, mj);
      csr_write(CSR_MAX_GAP, mg);
      csr_write(CSR_GAP_THRESH, th);
      csr_write(CSR_WALK_DIR, dir);
   endtask

   task automatic wait_idle();
      while (point_queue.size() > 0 || holding || quality_queue.size() > 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // one profile line; mode 0 smooth, 1 with gaps, 2 with jumps, 3 noise
   task automatic push_line(input int n, input int ws, input int we, input bit inv,
                            input int mode);
      point_t p;
      int     h;
      h = $urandom_range(0, 65535);
      for (int k = 0; k < n; k++) begin
         if (mode == 3) begin
            p.height = $urandom;
            p.rank = $urandom_range(0, 3) == 0 ? 8'd0 : 8'($urandom);
         end else begin
            h = h + $urandom_range(0, 120) - 60;
            if (mode == 2 && $urandom_range(0, 9) == 0) h = h + $urandom_range(0, 4000) - 2000;
            if (h < 0) h = 0;
            if (h > 65535) h = 65535;
            p.height = 16'(h);
            p.rank = $urandom_range(1, 255);
            if (mode == 1 && $urandom_range(0, 5) == 0) p.rank = 0;
         end
         p.last = (k == n - 1);
         p.wstart = p.last ? 13'(ws) : 13'($urandom);
         p.wend = p.last ? 13'(we) : 13'($urandom);
         p.invalid = p.last ? inv : 1'($urandom);
         point_queue.push_back(p);
      end
   endtask

   initial begin
      int n, ws, we, sent;
      req_bus.valid = 0;
      req_bus.sample_height = 0;
      req_bus.sample_rank = 0;
      req_bus.window_start = 0;
      req_bus.window_end = 0;
      req_bus.frame_invalid = 0;
      req_bus.last_point = 0;
      rsp_bus.ready = 0;
      csr_bus.valid = 0;
      csr_bus.index = CSR_MAX_JUMP;
      csr_bus.wdata = 0;
      cur = '{default: '0};
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed lines at reset configuration, then at zero limits walking from the right
      push_line(1, 0, 0, 0, 0);
      push_line(8, 7, 0, 0, 1);
      push_line(6, -2048, 4095, 0, 2);
      push_line(5, 4095, 3000, 0, 0);
      push_line(4, 1, 2, 1, 0);
      wait_idle();
      set_config(0, 0, 0, 1);
      push_line(3, -1, -2048, 0, 3);
      for (int k = 0; k < 3; k++) begin
         point_queue.push_back('{16'hFFFF, 8'd255, 13'sd0, 13'sd0, 1'b0, 1'b0});
         point_queue.push_back('{16'h0000, 8'd0, 13'sd0, 13'sd0, 1'b0, 1'b0});
      end
      point_queue.push_back('{16'hFFFF, 8'd255, 13'sd0, 13'sd6, 1'b0, 1'b1});
      wait_idle();

      // widest register values, wide windows and long valid runs
      set_config(4095, 1023, 25600, 0);
      push_line(20, 0, 4095, 0, 1);
      push_line(24, 2, 21, 0, 0);
      wait_idle();
      set_config(4095, 1023, 12800, 1);
      push_line(24, -5, 2000, 0, 0);
      wait_idle();

      sent = 0;
      for (int phase = 0; phase < 6; phase++) begin
         if (phase == 5) quiet = 1'b1;
         set_config($urandom_range(0, 3) == 0 ? $urandom_range(0, 4095) : $urandom_range(1, 30),
                    $urandom_range(0, 3) == 0 ? $urandom_range(0, 1023) : $urandom_range(0, 4),
                    $urandom_range(0, 25600), $urandom_range(0, 1));
         for (int l = 0; l < 5; l++) begin
            n = $urandom_range(1, 4) == 1 ? $urandom_range(1, 6) : $urandom_range(8, 24);
            if ($urandom_range(0, 4) == 0) begin
               ws = $urandom_range(0, 6143) - 2048;
               we = $urandom_range(0, 6143) - 2048;
            end else begin
               ws = $urandom_range(0, n);
               we = $urandom_range(0, n + 1);
            end
            push_line(n, ws, we, $urandom_range(0, 15) == 0,
                      $urandom_range(0, 9) == 0 ? 3 : $urandom_range(0, 2));
            sent += n;
         end
         wait_idle();
      end

      repeat (50) @(posedge clock);
      if (errors == 0) $display("PASS laser_line_seam_tracking_quality_unit");
      else $display("FAIL laser_line_seam_tracking_quality_unit");
      $finish;
   end

endmodule
